/* hw/rtl/dllc_pkg.sv */
// ----------------------------------------------------------------------------
// dllc_pkg
// Command codes and state encoding for the linked list with cursor.
// ----------------------------------------------------------------------------
`default_nettype none
package dllc_pkg;
    typedef enum logic [3:0] {
        CMD_NOP        = 4'd0,
        CMD_INS_HEAD   = 4'd1,
        CMD_INS_TAIL   = 4'd2,
        CMD_POP_HEAD   = 4'd3,
        CMD_POP_TAIL   = 4'd4,
        CMD_CUR_HEAD   = 4'd5,
        CMD_CUR_TAIL   = 4'd6,
        CMD_FWD        = 4'd7,
        CMD_BACK       = 4'd8,
        CMD_INS_AFTER  = 4'd9,
        CMD_INS_BEFORE = 4'd10,
        CMD_DELETE     = 4'd11
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_FIX   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;
endpackage
`default_nettype wire

/* hw/rtl/doubly_linked_list_with_cursor.sv */
// ----------------------------------------------------------------------------
// doubly_linked_list_with_cursor
// Bounded doubly linked list in a node pool, with a free stack and a cursor.
// ----------------------------------------------------------------------------
// Each command is accepted in ST_IDLE, then issues reads of the cursor's node
// and the free stack top in ST_READ, updates links and registers in ST_EXEC,
// reads the snapshot payloads from the node memory in ST_FIX and registers the
// result in ST_OUT. The input stays blocked while a result waits, so the next
// command is accepted the cycle after the result transfer.
// Links and payloads live in synchronous memories with registered reads;
// head, tail and cursor payloads are kept in registers so the snapshot needs
// no extra memory port. The free stack resets to all indices through a
// high-water mark of the depths written by pops, so no clearing pass is needed.
`default_nettype none
module doubly_linked_list_with_cursor #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,  // command[3:0], value[35:4], zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata   // done_ok, removed, head, tail, cursor,
                                        // item_count[7], cursor_valid,
                                        // at_first, at_last, zero pad
);
    import dllc_pkg::*;

    localparam int IW = $clog2(CAPACITY) + 1;  // index with nil marker
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    // node memories
    logic [VALUE_WIDTH-1:0] pay_mem [CAPACITY];
    logic [IW-1:0]          nxt_mem [CAPACITY];
    logic [IW-1:0]          prv_mem [CAPACITY];
    logic [AW-1:0]          fre_mem [CAPACITY];

    state_t state_reg;
    cmd_t   cmd_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [IW-1:0] head_reg, tail_reg, cur_reg, cnt_reg;
    logic [VALUE_WIDTH-1:0] headv_reg, tailv_reg, curv_reg;
    logic [IW-1:0] fill_reg;   // free-stack depths below this have been written
    logic [IW-1:0] cn_reg, cp_reg;  // cursor next / prev
    logic [AW-1:0] fr_reg;
    logic ok_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    // pending second-phase fixups
    logic fx_pay_reg;
    logic [IW-1:0] fx_idx_reg;
    logic [1:0] fx_sel_reg;   // bit0: refresh head, bit1 tail
    logic fx_cur_reg;

    function automatic logic isn(input logic [IW-1:0] i);
        return i < NIL;
    endfunction

    logic [AW-1:0] stk_top;
    assign stk_top = AW'(IW'(CAPACITY - 1) - cnt_reg);

    // read ports: issued in ST_READ
    logic [AW-1:0] rd_a;
    assign rd_a = cur_reg[AW-1:0];
    logic [AW-1:0] p_addr;
    logic [VALUE_WIDTH-1:0] pay_rd_reg;

    // link writes, up to four per command; all done in ST_EXEC
    logic [IW-1:0] hn_reg, tp_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            cn_reg <= nxt_mem[rd_a];
            cp_reg <= prv_mem[rd_a];
            hn_reg <= nxt_mem[head_reg[AW-1:0]];
            tp_reg <= prv_mem[tail_reg[AW-1:0]];
            fr_reg <= fre_mem[stk_top];
        end
        pay_rd_reg <= pay_mem[p_addr];
    end

    // an unwritten free-stack slot is not read; its index is taken to equal its depth
    logic [IW-1:0] free_idx;
    assign free_idx = (fill_reg > cnt_reg) ? IW'(fr_reg) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cur_reg   <= NIL;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            m_tvalid  <= 1'b0;
            fx_pay_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg   <= cmd_t'(s_tdata[3:0]);
                        val_reg   <= VALUE_WIDTH'(s_tdata[35:4]);
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    ok_reg     <= 1'b0;
                    rem_reg    <= '0;
                    fx_pay_reg <= 1'b0;
                    fx_sel_reg <= 2'b00;
                    fx_cur_reg <= 1'b0;
                    state_reg  <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= ST_FIX;
                    unique case (cmd_reg)
                        CMD_INS_HEAD, CMD_INS_TAIL: begin
                            if (cnt_reg < NIL) begin
                                ok_reg <= 1'b1;
                                cnt_reg <= cnt_reg + 1'b1;
                                pay_mem[free_idx[AW-1:0]] <= val_reg;
                                if (!isn(head_reg)) begin
                                    head_reg <= free_idx; tail_reg <= free_idx;
                                    nxt_mem[free_idx[AW-1:0]] <= NIL;
                                    prv_mem[free_idx[AW-1:0]] <= NIL;
                                    headv_reg <= val_reg; tailv_reg <= val_reg;
                                end else if (cmd_reg == CMD_INS_HEAD) begin
                                    nxt_mem[free_idx[AW-1:0]] <= head_reg;
                                    prv_mem[free_idx[AW-1:0]] <= NIL;
                                    prv_mem[head_reg[AW-1:0]] <= free_idx;
                                    head_reg <= free_idx; headv_reg <= val_reg;
                                end else begin
                                    prv_mem[free_idx[AW-1:0]] <= tail_reg;
                                    nxt_mem[free_idx[AW-1:0]] <= NIL;
                                    nxt_mem[tail_reg[AW-1:0]] <= free_idx;
                                    tail_reg <= free_idx; tailv_reg <= val_reg;
                                end
                            end
                        end
                        CMD_POP_HEAD, CMD_POP_TAIL: begin
                            if (cnt_reg != 0) begin
                                ok_reg <= 1'b1;
                                cnt_reg <= cnt_reg - 1'b1;
                                if (cmd_reg == CMD_POP_HEAD) begin
                                    rem_reg <= headv_reg;
                                    fre_mem[AW'(IW'(CAPACITY) - cnt_reg)] <= head_reg[AW-1:0];
                                    if (cur_reg == head_reg) cur_reg <= NIL;
                                    head_reg <= hn_reg;
                                    if (isn(hn_reg)) begin
                                        prv_mem[hn_reg[AW-1:0]] <= NIL;
                                        fx_idx_reg <= hn_reg; fx_sel_reg <= 2'b01;
                                        fx_pay_reg <= 1'b1;
                                    end else tail_reg <= NIL;
                                end else begin
                                    rem_reg <= tailv_reg;
                                    fre_mem[AW'(IW'(CAPACITY) - cnt_reg)] <= tail_reg[AW-1:0];
                                    if (cur_reg == tail_reg) cur_reg <= NIL;
                                    tail_reg <= tp_reg;
                                    if (isn(tp_reg)) begin
                                        nxt_mem[tp_reg[AW-1:0]] <= NIL;
                                        fx_idx_reg <= tp_reg; fx_sel_reg <= 2'b10;
                                        fx_pay_reg <= 1'b1;
                                    end else head_reg <= NIL;
                                end
                            end
                        end
                        CMD_CUR_HEAD, CMD_CUR_TAIL: begin
                            if (cnt_reg != 0) begin
                                ok_reg <= 1'b1;
                                cur_reg <= (cmd_reg == CMD_CUR_HEAD) ? head_reg : tail_reg;
                                curv_reg <= (cmd_reg == CMD_CUR_HEAD) ? headv_reg
                                                                      : tailv_reg;
                            end
                        end
                        CMD_FWD, CMD_BACK: begin
                            if (isn(cur_reg)) begin
                                if (cmd_reg == CMD_FWD && isn(cn_reg)) begin
                                    ok_reg <= 1'b1; cur_reg <= cn_reg;
                                    fx_idx_reg <= cn_reg; fx_cur_reg <= 1'b1;
                                    fx_pay_reg <= 1'b1;
                                end else if (cmd_reg == CMD_BACK && isn(cp_reg)) begin
                                    ok_reg <= 1'b1; cur_reg <= cp_reg;
                                    fx_idx_reg <= cp_reg; fx_cur_reg <= 1'b1;
                                    fx_pay_reg <= 1'b1;
                                end
                            end
                        end
                        CMD_INS_AFTER, CMD_INS_BEFORE: begin
                            if ((cnt_reg == 0 || isn(cur_reg)) && cnt_reg < NIL) begin
                                ok_reg <= 1'b1;
                                cnt_reg <= cnt_reg + 1'b1;
                                pay_mem[free_idx[AW-1:0]] <= val_reg;
                                if (cnt_reg == 0) begin
                                    head_reg <= free_idx; tail_reg <= free_idx;
                                    cur_reg <= free_idx;
                                    nxt_mem[free_idx[AW-1:0]] <= NIL;
                                    prv_mem[free_idx[AW-1:0]] <= NIL;
                                    headv_reg <= val_reg; tailv_reg <= val_reg;
                                    curv_reg <= val_reg;
                                end else if (cmd_reg == CMD_INS_AFTER) begin
                                    nxt_mem[free_idx[AW-1:0]] <= cn_reg;
                                    prv_mem[free_idx[AW-1:0]] <= cur_reg;
                                    nxt_mem[rd_a] <= free_idx;
                                    if (isn(cn_reg)) prv_mem[cn_reg[AW-1:0]] <= free_idx;
                                    else begin
                                        tail_reg <= free_idx; tailv_reg <= val_reg;
                                    end
                                end else begin
                                    prv_mem[free_idx[AW-1:0]] <= cp_reg;
                                    nxt_mem[free_idx[AW-1:0]] <= cur_reg;
                                    prv_mem[rd_a] <= free_idx;
                                    if (isn(cp_reg)) nxt_mem[cp_reg[AW-1:0]] <= free_idx;
                                    else begin
                                        head_reg <= free_idx; headv_reg <= val_reg;
                                    end
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (cnt_reg != 0 && isn(cur_reg)) begin
                                ok_reg <= 1'b1;
                                cnt_reg <= cnt_reg - 1'b1;
                                rem_reg <= curv_reg;
                                fre_mem[AW'(IW'(CAPACITY) - cnt_reg)] <= rd_a;
                                if (isn(cp_reg)) nxt_mem[cp_reg[AW-1:0]] <= cn_reg;
                                else head_reg <= cn_reg;
                                if (isn(cn_reg)) prv_mem[cn_reg[AW-1:0]] <= cp_reg;
                                else tail_reg <= cp_reg;
                                cur_reg <= isn(cn_reg) ? cn_reg : cp_reg;
                                if (isn(cn_reg) || isn(cp_reg)) begin
                                    fx_idx_reg <= isn(cn_reg) ? cn_reg : cp_reg;
                                    fx_cur_reg <= 1'b1;
                                    fx_sel_reg <= {!isn(cn_reg), !isn(cp_reg)};
                                    fx_pay_reg <= 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    // a pop at count n writes free-stack depth n-1
                    if ((cmd_reg == CMD_POP_HEAD || cmd_reg == CMD_POP_TAIL ||
                         cmd_reg == CMD_DELETE) && cnt_reg > fill_reg)
                        fill_reg <= cnt_reg;
                end
                ST_FIX: state_reg <= ST_OUT;  // payload read in flight
                ST_OUT: begin
                    if (fx_pay_reg) begin
                        if (fx_sel_reg[0]) headv_reg <= pay_rd_reg;
                        if (fx_sel_reg[1]) tailv_reg <= pay_rd_reg;
                        if (fx_cur_reg) curv_reg <= pay_rd_reg;
                        fx_pay_reg <= 1'b0;
                    end
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
        end
    end

    assign p_addr = fx_idx_reg[AW-1:0];

    // snapshot outputs are sampled from registers once m_tvalid is raised
    logic empty;
    assign empty = (cnt_reg == 0);
    logic [VALUE_WIDTH-1:0] hv, tv, cv;
    assign hv = empty ? '0 : headv_reg;
    assign tv = empty ? '0 : tailv_reg;
    assign cv = isn(cur_reg) ? curv_reg : '0;

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;
    assign m_tdata = {5'd0, (empty || cur_reg == tail_reg), (empty || cur_reg == head_reg),
                      isn(cur_reg), 7'(cnt_reg), 32'(cv), 32'(tv), 32'(hv),
                      32'(rem_reg), ok_reg};
endmodule
`default_nettype wire

/* hw/rtl/dllc_checker.sv */
// ----------------------------------------------------------------------------
// dllc_checker
// Port-level checks for the linked list with cursor.
// ----------------------------------------------------------------------------
`default_nettype none
module dllc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata
);
    // no new command while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepted with result pending");
    // a result never follows an accepted transfer at once
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("early result");
    // empty list reports both flags and no cursor
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[135:129] == 7'd0) |-> (m_tdata[137] && m_tdata[138] &&
        !m_tdata[136])) else $error("empty flags");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
endmodule

bind doubly_linked_list_with_cursor dllc_checker u_dllc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs a directed command table and then random fill and drain phases into
// the linked list with cursor. Each accepted command is run through a local
// list model; every returned snapshot is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import dllc_pkg::*;

    localparam logic [6:0] NIL         = 7'd64;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         PHASE_ITEMS = 52;
    localparam int         NUM_PHASES  = 12;

    typedef struct packed {
        logic        at_last;
        logic        at_first;
        logic        cursor_valid;
        logic [6:0]  item_count;
        logic [31:0] cursor_value;
        logic [31:0] tail_payload;
        logic [31:0] head_payload;
        logic [31:0] removed_value;
        logic        done_ok;
    } snapshot_t;

    // directed rows: typed expectation for done_ok and count where obvious
    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] val;
        bit          typed;
        logic        ok;
        logic [6:0]  cnt;
    } cmd_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;   // command[3:0], value[35:4], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;   // done_ok, removed, head, tail, cursor, count,
                             // cursor_valid, at_first, at_last, zero pad

    doubly_linked_list_with_cursor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // list model state
    logic [31:0] node_val [64];
    logic [6:0]  link_next [64];
    logic [6:0]  link_prev [64];
    logic [6:0]  free_idx [64];
    logic [6:0]  head_idx, tail_idx, cur_idx, held;

    snapshot_t snap_queue[$];
    int        errors;
    int        idle_cycles;
    int        hold_off;
    bit        stim_done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit is_node(logic [6:0] i);
        return i < NIL;
    endfunction

    function automatic logic [31:0] val_at(logic [6:0] i);
        return is_node(i) ? node_val[i[5:0]] : 32'd0;
    endfunction

    function automatic void list_clear();
        for (int i = 0; i < 64; i++) begin
            free_idx[i] = 7'(63 - i);
        end
        head_idx = NIL;
        tail_idx = NIL;
        cur_idx  = NIL;
        held     = 7'd0;
    endfunction

    function automatic logic [6:0] alloc_node(logic [31:0] v);
        logic [6:0] n;
        if (held >= 7'd64) return NIL;
        n = free_idx[6'(63 - held)];
        node_val[n[5:0]]  = v;
        link_next[n[5:0]] = NIL;
        link_prev[n[5:0]] = NIL;
        held++;
        return n;
    endfunction

    function automatic logic [31:0] unlink_node(logic [6:0] i);
        logic [6:0] p, n;
        p = link_prev[i[5:0]];
        n = link_next[i[5:0]];
        if (is_node(p)) link_next[p[5:0]] = n; else head_idx = n;
        if (is_node(n)) link_prev[n[5:0]] = p; else tail_idx = p;
        held--;
        free_idx[6'(63 - held)] = i;
        return node_val[i[5:0]];
    endfunction

    function automatic snapshot_t run_command(logic [3:0] cmd, logic [31:0] v);
        snapshot_t  r;
        logic [6:0] n, c, nb;
        r = '0;
        c = cur_idx;
        case (cmd)
            CMD_INS_HEAD, CMD_INS_TAIL: begin
                n = alloc_node(v);
                if (is_node(n)) begin
                    r.done_ok = 1'b1;
                    if (!is_node(head_idx)) begin
                        head_idx = n;
                        tail_idx = n;
                    end else if (cmd == CMD_INS_HEAD) begin
                        link_next[n[5:0]] = head_idx;
                        link_prev[head_idx[5:0]] = n;
                        head_idx = n;
                    end else begin
                        link_prev[n[5:0]] = tail_idx;
                        link_next[tail_idx[5:0]] = n;
                        tail_idx = n;
                    end
                end
            end
            CMD_POP_HEAD, CMD_POP_TAIL: begin
                n = (cmd == CMD_POP_HEAD) ? head_idx : tail_idx;
                if (held != 0 && is_node(n)) begin
                    if (cur_idx == n) cur_idx = NIL;
                    r.removed_value = unlink_node(n);
                    r.done_ok = 1'b1;
                end
            end
            CMD_CUR_HEAD, CMD_CUR_TAIL: begin
                if (held != 0) begin
                    cur_idx = (cmd == CMD_CUR_HEAD) ? head_idx : tail_idx;
                    r.done_ok = is_node(cur_idx);
                end
            end
            CMD_FWD, CMD_BACK: begin
                if (is_node(c)) begin
                    n = (cmd == CMD_FWD) ? link_next[c[5:0]] : link_prev[c[5:0]];
                    if (is_node(n)) begin
                        cur_idx = n;
                        r.done_ok = 1'b1;
                    end
                end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
                if (held == 0 || is_node(c)) begin
                    n = alloc_node(v);
                    if (is_node(n)) begin
                        r.done_ok = 1'b1;
                        if (held == 1) begin
                            head_idx = n;
                            tail_idx = n;
                            cur_idx  = n;
                        end else if (cmd == CMD_INS_AFTER) begin
                            nb = link_next[c[5:0]];
                            link_next[n[5:0]] = nb;
                            link_prev[n[5:0]] = c;
                            if (is_node(nb)) link_prev[nb[5:0]] = n; else tail_idx = n;
                            link_next[c[5:0]] = n;
                        end else begin
                            nb = link_prev[c[5:0]];
                            link_prev[n[5:0]] = nb;
                            link_next[n[5:0]] = c;
                            if (is_node(nb)) link_next[nb[5:0]] = n; else head_idx = n;
                            link_prev[c[5:0]] = n;
                        end
                    end
                end
            end
            CMD_DELETE: begin
                if (held != 0 && is_node(c)) begin
                    // cursor slides forward, else back, else goes nil
                    n = is_node(link_next[c[5:0]]) ? link_next[c[5:0]] : link_prev[c[5:0]];
                    r.removed_value = unlink_node(c);
                    cur_idx = is_node(n) ? n : NIL;
                    r.done_ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (held != 0) begin
            r.head_payload = val_at(head_idx);
            r.tail_payload = val_at(tail_idx);
        end
        r.cursor_value = val_at(cur_idx);
        r.item_count   = held;
        r.cursor_valid = is_node(cur_idx);
        r.at_first     = (held == 0) || (cur_idx == head_idx);
        r.at_last      = (held == 0) || (cur_idx == tail_idx);
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // sender: one command per call, valid held across back-to-back transfers
    task automatic send_command(logic [3:0] cmd, logic [31:0] v, bit typed,
                                logic ok, logic [6:0] cnt);
        int        gap;
        snapshot_t exp;
        gap = (stim_done || $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, v, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp = run_command(cmd, v);
        if (typed) begin
            exp.done_ok    = ok;
            exp.item_count = cnt;
        end
        snap_queue.push_back(exp);
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) stall = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        snapshot_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = snapshot_t'(m_tdata[138:0]);
            if (snap_queue.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                exp = snap_queue.pop_front();
                if (got.done_ok !== exp.done_ok) begin
                    $error("done_ok exp %0h got %0h", exp.done_ok, got.done_ok);
                    errors++;
                end
                if (got.removed_value !== exp.removed_value) begin
                    $error("removed_value exp %0h got %0h", exp.removed_value,
                           got.removed_value);
                    errors++;
                end
                if (got.head_payload !== exp.head_payload) begin
                    $error("head_payload exp %0h got %0h", exp.head_payload,
                           got.head_payload);
                    errors++;
                end
                if (got.tail_payload !== exp.tail_payload) begin
                    $error("tail_payload exp %0h got %0h", exp.tail_payload,
                           got.tail_payload);
                    errors++;
                end
                if (got.cursor_value !== exp.cursor_value) begin
                    $error("cursor_value exp %0h got %0h", exp.cursor_value,
                           got.cursor_value);
                    errors++;
                end
                if (got.item_count !== exp.item_count) begin
                    $error("item_count exp %0d got %0d", exp.item_count, got.item_count);
                    errors++;
                end
                if (got.cursor_valid !== exp.cursor_valid) begin
                    $error("cursor_valid exp %0h got %0h", exp.cursor_valid,
                           got.cursor_valid);
                    errors++;
                end
                if (got.at_first !== exp.at_first) begin
                    $error("at_first exp %0h got %0h", exp.at_first, got.at_first);
                    errors++;
                end
                if (got.at_last !== exp.at_last) begin
                    $error("at_last exp %0h got %0h", exp.at_last, got.at_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** doubly_linked_list_with_cursor: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    cmd_row_t directed [] = '{
        '{CMD_POP_HEAD,   32'h0,        1, 1'b0, 7'd0},
        '{CMD_POP_TAIL,   32'h0,        1, 1'b0, 7'd0},
        '{CMD_CUR_HEAD,   32'h0,        1, 1'b0, 7'd0},
        '{CMD_CUR_TAIL,   32'h0,        1, 1'b0, 7'd0},
        '{CMD_FWD,        32'h0,        1, 1'b0, 7'd0},
        '{CMD_BACK,       32'h0,        1, 1'b0, 7'd0},
        '{CMD_DELETE,     32'h0,        1, 1'b0, 7'd0},
        '{CMD_NOP,        32'h1234,     1, 1'b0, 7'd0},
        '{4'd12,          32'h5,        1, 1'b0, 7'd0},
        '{4'd15,          32'hFFFFFFFF, 1, 1'b0, 7'd0},
        '{CMD_INS_AFTER,  32'hA5A5A5A5, 1, 1'b1, 7'd1},
        '{CMD_POP_HEAD,   32'h0,        1, 1'b1, 7'd0},
        '{CMD_INS_HEAD,   32'h0,        1, 1'b1, 7'd1},
        '{CMD_INS_TAIL,   32'hFFFFFFFF, 1, 1'b1, 7'd2},
        '{CMD_INS_BEFORE, 32'h11,       1, 1'b0, 7'd2},
        '{CMD_CUR_TAIL,   32'h0,        0, 1'b0, 7'd0},
        '{CMD_FWD,        32'h0,        0, 1'b0, 7'd0},
        '{CMD_INS_BEFORE, 32'h5A5A5A5A, 0, 1'b0, 7'd0},
        '{CMD_BACK,       32'h0,        0, 1'b0, 7'd0},
        '{CMD_INS_AFTER,  32'h22,       0, 1'b0, 7'd0},
        '{CMD_DELETE,     32'h0,        0, 1'b0, 7'd0},
        '{CMD_CUR_HEAD,   32'h0,        0, 1'b0, 7'd0},
        '{CMD_POP_HEAD,   32'h0,        0, 1'b0, 7'd0},
        '{CMD_DELETE,     32'h0,        0, 1'b0, 7'd0},
        '{CMD_CUR_TAIL,   32'h0,        0, 1'b0, 7'd0}
    };

    initial begin
        logic [3:0] cmd;
        int         roll;
        bit         filling;
        errors      = 0;
        idle_cycles = 0;
        hold_off    = 0;
        stim_done   = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        list_clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_command(directed[i].cmd, directed[i].val, directed[i].typed,
                         directed[i].ok, directed[i].cnt);
        end

        // alternate fill and drain phases so the pool hits full and empty
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            filling = (ph % 2 == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 3 && k == 10) hold_off = 300;
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    cmd = ($urandom_range(0, 1) == 0) ? 4'(CMD_NOP)
                                                      : 4'($urandom_range(12, 15));
                end else if (roll < (filling ? 70 : 25)) begin
                    cmd = 4'($urandom_range(CMD_INS_HEAD, CMD_INS_TAIL));
                    if ($urandom_range(0, 1) == 0)
                        cmd = 4'($urandom_range(CMD_INS_AFTER, CMD_INS_BEFORE));
                end else if (roll < (filling ? 80 : 65)) begin
                    cmd = ($urandom_range(0, 1) == 0) ? 4'(CMD_DELETE)
                                                      : 4'($urandom_range(CMD_POP_HEAD,
                                                                          CMD_POP_TAIL));
                end else begin
                    cmd = 4'($urandom_range(CMD_CUR_HEAD, CMD_BACK));
                end
                send_command(cmd, $urandom(), 1'b0, 1'b0, 7'd0);
            end
        end
        stim_done = 1'b1;
        s_tvalid <= 1'b0;

        while (snap_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("** doubly_linked_list_with_cursor: PASSED **");
        end else begin
            $display("** doubly_linked_list_with_cursor: FAILED **");
        end
        $finish;
    end
endmodule

/* doubly_linked_list_with_cursor.f */
hw/rtl/dllc_pkg.sv
hw/rtl/doubly_linked_list_with_cursor.sv
hw/rtl/dllc_checker.sv
dv/testbench.sv
